// ===== design/vcmc_pkg.sv =====
`default_nettype none

package vcmc_pkg;

  localparam int VERTEX_W  = 16;
  localparam int MISS_W    = 2;
  localparam int TOTAL_W   = 32;
  localparam int TRI_VERTS = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [MISS_W-1:0]  triangle_misses;
    logic [TOTAL_W-1:0] total_misses;
    logic               mesh_done;
  } result_t;

endpackage

`default_nettype wire

// ===== design/vcmc_if.sv =====
`default_nettype none

interface vcmc_tri_if;
  import vcmc_pkg::*;

  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;
  logic [VERTEX_W-1:0] vertex_c;
  logic                last_triangle;

  modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                  output last_triangle, input ready);
  modport sink (input valid, input vertex_a, input vertex_b, input vertex_c,
                input last_triangle, output ready);
endinterface

interface vcmc_res_if;
  import vcmc_pkg::*;

  logic               valid;
  logic               ready;
  logic [MISS_W-1:0]  triangle_misses;
  logic [TOTAL_W-1:0] total_misses;
  logic               mesh_done;

  modport source (output valid, output triangle_misses, output total_misses,
                  output mesh_done, input ready);
  modport sink (input valid, input triangle_misses, input total_misses,
                input mesh_done, output ready);
endinterface

`default_nettype wire

// ===== design/vcmc_lane.sv =====
`default_nettype none

module vcmc_lane #(
  parameter int CACHE_DEPTH = 8,
  parameter int KEY_W       = 16,
  parameter int FILL_W      = 4,
  parameter int IDX_W       = 3
) (
  input  wire logic [KEY_W-1:0]  entries [CACHE_DEPTH],
  input  wire logic [FILL_W-1:0] fill,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   hit,
  output logic [IDX_W-1:0]       pos
);
  import vcmc_pkg::*;

  logic [CACHE_DEPTH-1:0] match;

  always_comb begin
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      match[i] = (FILL_W'(i) < fill) && (entries[i] == key);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = IDX_W'(i);
      end
    end
  end

  assign hit = |match;

endmodule

`default_nettype wire

// ===== design/vcmc_step.sv =====
`default_nettype none

module vcmc_step #(
  parameter int CACHE_DEPTH = 8,
  parameter int KEY_W       = 16,
  parameter int FILL_W      = 4,
  parameter int IDX_W       = 3
) (
  input  wire logic [KEY_W-1:0]  entries_cur [CACHE_DEPTH],
  input  wire logic [FILL_W-1:0] fill_cur,
  input  wire logic [KEY_W-1:0]  key,
  output logic [KEY_W-1:0]       entries_nxt [CACHE_DEPTH],
  output logic [FILL_W-1:0]      fill_nxt
);
  import vcmc_pkg::*;

  logic              hit;
  logic [IDX_W-1:0]  pos;
  logic [FILL_W-1:0] back_full;
  logic [IDX_W-1:0]  back;
  logic [KEY_W-1:0]  at_pos;
  logic [KEY_W-1:0]  at_back;
  logic              full;

  vcmc_lane #(
    .CACHE_DEPTH(CACHE_DEPTH),
    .KEY_W      (KEY_W),
    .FILL_W     (FILL_W),
    .IDX_W      (IDX_W)
  ) u_lane (
    .entries(entries_cur),
    .fill   (fill_cur),
    .key    (key),
    .hit    (hit),
    .pos    (pos)
  );

  assign back_full = fill_cur - FILL_W'(1);
  assign back      = back_full[IDX_W-1:0];
  assign at_pos    = entries_cur[pos];
  assign at_back   = entries_cur[back];
  assign full      = (fill_cur == FILL_W'(CACHE_DEPTH));

  always_comb begin
    entries_nxt = entries_cur;
    if (hit) begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (IDX_W'(i) == back) begin
          entries_nxt[i] = at_pos;
        end else if (IDX_W'(i) == pos) begin
          entries_nxt[i] = at_back;
        end
      end
    end else if (full) begin
      // drop the front entry, append at the back
      for (int i = 0; i < CACHE_DEPTH - 1; i++) begin
        entries_nxt[i] = entries_cur[i+1];
      end
      entries_nxt[CACHE_DEPTH-1] = key;
    end else begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (FILL_W'(i) == fill_cur) begin
          entries_nxt[i] = key;
        end
      end
    end
  end

  assign fill_nxt = (hit || full) ? fill_cur : fill_cur + FILL_W'(1);

endmodule

`default_nettype wire

// ===== design/vertex_cache_miss_counter.sv =====
// Channel    Port      Dir  Payload
// --------   --------  ---  ----------------------------------------------------
// triangle   triangle  in   vertex_a, vertex_b, vertex_c, last_triangle
// result     result    out  triangle_misses, total_misses, mesh_done
//
// One triangle per cycle while input ready is high; each result is registered, in the skid while the output stalls.
// Lookup, three chained cache updates and the total are all combinational ahead
// of the cache registers; that path sets the clock.
// Reset empties the cache and clears the total; entries are not cleared.
// A two-deep output (register plus skid) lets the input take one more triangle after the output stalls.
`default_nettype none

module vertex_cache_miss_counter #(
  parameter int CACHE_DEPTH = 8,
  parameter int INDEX_BITS  = 16
) (
  input wire logic clk,
  input wire logic rst,
  vcmc_tri_if.sink   triangle,
  vcmc_res_if.source result
);
  import vcmc_pkg::*;

  localparam int KEY_W  = (INDEX_BITS < VERTEX_W) ? INDEX_BITS : VERTEX_W;
  localparam int FILL_W = $clog2(CACHE_DEPTH + 1);
  localparam int IDX_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  logic [KEY_W-1:0]  entries [CACHE_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [TOTAL_W-1:0] miss_total;

  logic [KEY_W-1:0]  keys [TRI_VERTS];
  logic [TRI_VERTS-1:0] hits;
  logic [IDX_W-1:0]  lane_pos [TRI_VERTS];

  logic [KEY_W-1:0]  stage_entries [TRI_VERTS+1][CACHE_DEPTH];
  logic [FILL_W-1:0] stage_fill [TRI_VERTS+1];

  logic               accept;
  logic [MISS_W-1:0]  misses;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_next;
  result_t            res_next;

  result_t out_data;
  logic    out_valid;
  result_t skid_data;
  logic    skid_valid;

  assign keys[0] = triangle.vertex_a[KEY_W-1:0];
  assign keys[1] = triangle.vertex_b[KEY_W-1:0];
  assign keys[2] = triangle.vertex_c[KEY_W-1:0];

  assign stage_entries[0] = entries;
  assign stage_fill[0]    = fill;

  for (genvar k = 0; k < TRI_VERTS; k++) begin : g_vert
    vcmc_lane #(
      .CACHE_DEPTH(CACHE_DEPTH),
      .KEY_W      (KEY_W),
      .FILL_W     (FILL_W),
      .IDX_W      (IDX_W)
    ) u_lane (
      .entries(entries),
      .fill   (fill),
      .key    (keys[k]),
      .hit    (hits[k]),
      .pos    (lane_pos[k])
    );

    vcmc_step #(
      .CACHE_DEPTH(CACHE_DEPTH),
      .KEY_W      (KEY_W),
      .FILL_W     (FILL_W),
      .IDX_W      (IDX_W)
    ) u_step (
      .entries_cur(stage_entries[k]),
      .fill_cur   (stage_fill[k]),
      .key        (keys[k]),
      .entries_nxt(stage_entries[k+1]),
      .fill_nxt   (stage_fill[k+1])
    );
  end

  assign misses = MISS_W'(!hits[0]) + MISS_W'(!hits[1]) + MISS_W'(!hits[2]);
  assign sum    = {1'b0, miss_total} + (TOTAL_W+1)'(misses);
  assign total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    res_next.triangle_misses = misses;
    res_next.total_misses    = total_next;
    res_next.mesh_done       = triangle.last_triangle;
  end

  assign triangle.ready = !skid_valid;
  assign accept         = triangle.valid && triangle.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      entries <= stage_entries[TRI_VERTS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      miss_total <= '0;
    end else if (accept) begin
      fill       <= triangle.last_triangle ? '0 : stage_fill[TRI_VERTS];
      miss_total <= triangle.last_triangle ? '0 : total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_data <= skid_valid ? skid_data : res_next;
    end else if (accept) begin
      skid_data <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.triangle_misses = out_data.triangle_misses;
  assign result.total_misses    = out_data.total_misses;
  assign result.mesh_done       = out_data.mesh_done;

endmodule

`default_nettype wire

// ===== design/vcmc_checker.sv =====
`default_nettype none

module vcmc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [vcmc_pkg::MISS_W-1:0]    triangle_misses,
  input wire logic [vcmc_pkg::TOTAL_W-1:0]   total_misses,
  input wire logic                           mesh_done
);
  import vcmc_pkg::*;

  logic               have_prev;
  logic               prev_done;
  logic [TOTAL_W-1:0] prev_total;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] expected;
  logic               out_xfer;

  assign out_xfer = out_valid && out_ready;
  assign sum      = {1'b0, prev_total} + (TOTAL_W+1)'(triangle_misses);
  assign expected = (have_prev && !prev_done)
                  ? (sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0])
                  : TOTAL_W'(triangle_misses);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_xfer) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_done  <= mesh_done;
      prev_total <= total_misses;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(triangle_misses)
      && $stable(total_misses) && $stable(mesh_done))
    else $error("result changed while stalled");

  a_total_chain: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> total_misses == expected)
    else $error("running total does not follow the previous result");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_ready)
    else $error("input not ready after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing one cycle after transfer");

endmodule

bind vertex_cache_miss_counter vcmc_checker u_vcmc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (triangle.valid),
  .in_ready       (triangle.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .triangle_misses(result.triangle_misses),
  .total_misses   (result.total_misses),
  .mesh_done      (result.mesh_done)
);

`default_nettype wire

// ===== tb/vcmc_miss_monitor.sv =====
`default_nettype none

module vcmc_miss_monitor (
  input  wire logic clk,
  input  wire logic rst,
  vcmc_tri_if       triangle,
  vcmc_res_if       result,
  output int        fail_count,
  output int        pending
);
  import vcmc_pkg::*;

  localparam int CACHE_LINES = 8;

  logic [VERTEX_W-1:0] lines [CACHE_LINES];
  int                  fill;
  logic [TOTAL_W-1:0]  mesh_total;
  result_t             awaited_q [$];
  int                  errors;
  int                  awaited;

  assign fail_count = errors;
  assign pending    = awaited;

  initial begin
    errors  = 0;
    awaited = 0;
  end

  function automatic int locate(input logic [VERTEX_W-1:0] v);
    for (int i = 0; i < fill; i++) begin
      if (lines[i] == v) return i;
    end
    return -1;
  endfunction

  task automatic place(input logic [VERTEX_W-1:0] v);
    int                  pos;
    logic [VERTEX_W-1:0] held;
    pos = locate(v);
    if (pos >= 0) begin
      held            = lines[fill-1];
      lines[fill-1]   = lines[pos];
      lines[pos]      = held;
    end else if (fill < CACHE_LINES) begin
      lines[fill] = v;
      fill++;
    end else begin
      for (int i = 0; i < CACHE_LINES - 1; i++) lines[i] = lines[i+1];
      lines[CACHE_LINES-1] = v;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : track
    result_t             want;
    logic [VERTEX_W-1:0] v [TRI_VERTS];
    int                  misses;
    logic [TOTAL_W:0]    sum;
    if (rst) begin
      fill       = 0;
      mesh_total = '0;
      awaited_q.delete();
      awaited    = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result with none awaited: misses %0d total %0h done %0b",
                                    result.triangle_misses, result.total_misses,
                                    result.mesh_done));
        end else begin
          want = awaited_q[0];
          awaited_q.delete(0);
          if (result.triangle_misses !== want.triangle_misses)
            report_mismatch($sformatf("triangle_misses got %0d want %0d",
                                      result.triangle_misses, want.triangle_misses));
          if (result.total_misses !== want.total_misses)
            report_mismatch($sformatf("total_misses got %0h want %0h",
                                      result.total_misses, want.total_misses));
          if (result.mesh_done !== want.mesh_done)
            report_mismatch($sformatf("mesh_done got %0b want %0b",
                                      result.mesh_done, want.mesh_done));
        end
      end
      if (triangle.valid && triangle.ready) begin
        v[0]   = triangle.vertex_a;
        v[1]   = triangle.vertex_b;
        v[2]   = triangle.vertex_c;
        misses = 0;
        for (int k = 0; k < TRI_VERTS; k++) begin
          if (locate(v[k]) < 0) misses++;
        end
        for (int k = 0; k < TRI_VERTS; k++) place(v[k]);
        sum        = {1'b0, mesh_total} + (TOTAL_W+1)'(misses);
        mesh_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        want.triangle_misses = misses[MISS_W-1:0];
        want.total_misses    = mesh_total;
        want.mesh_done       = triangle.last_triangle;
        awaited_q.insert(awaited_q.size(), want);
        if (triangle.last_triangle) begin
          fill       = 0;
          mesh_total = '0;
        end
      end
      awaited = awaited_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/vertex_cache_miss_counter_tb.sv =====
`default_nettype none

module vertex_cache_miss_counter_tb;
  import vcmc_pkg::*;

  localparam int ITEMS = 1950;
  localparam int CALM  = 200;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;
  bit   calm;
  bit   long_hold_go;

  vcmc_tri_if triangle ();
  vcmc_res_if result ();

  vertex_cache_miss_counter dut (
    .clk      (clk),
    .rst      (rst),
    .triangle (triangle.sink),
    .result   (result.source)
  );

  vcmc_miss_monitor mon (
    .clk        (clk),
    .rst        (rst),
    .triangle   (triangle),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  task automatic send_triangle(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
                               input logic [VERTEX_W-1:0] c, input logic last);
    triangle.valid         <= 1'b1;
    triangle.vertex_a      <= a;
    triangle.vertex_b      <= b;
    triangle.vertex_c      <= c;
    triangle.last_triangle <= last;
    @(posedge clk);
    while (!triangle.ready) @(posedge clk);
    sent++;
  endtask

  task automatic hold_source(input int n);
    triangle.valid         <= 1'b0;
    triangle.vertex_a      <= VERTEX_W'($urandom);
    triangle.vertex_b      <= VERTEX_W'($urandom);
    triangle.vertex_c      <= VERTEX_W'($urandom);
    triangle.last_triangle <= 1'($urandom);
    repeat (n) @(posedge clk);
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : sink_side
    result.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        result.ready <= 1'b0;
        repeat (150) @(posedge clk);
        result.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result.ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        result.ready <= 1'b1;
        repeat ($urandom_range(1, 64)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  initial begin : source_side
    int                  mode;
    int                  len;
    int                  span;
    int                  gap_rate;
    int                  r;
    logic [VERTEX_W-1:0] base;
    logic [VERTEX_W-1:0] p1;
    logic [VERTEX_W-1:0] p2;
    logic [VERTEX_W-1:0] t [TRI_VERTS];
    logic                last;

    sent         = 0;
    calm         = 1'b0;
    long_hold_go = 1'b0;
    p1           = '0;
    p2           = '0;
    rst                    <= 1'b1;
    triangle.valid         <= 1'b0;
    triangle.vertex_a      <= '0;
    triangle.vertex_b      <= '0;
    triangle.vertex_c      <= '0;
    triangle.last_triangle <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_triangle(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_triangle(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_triangle(16'h0001, 16'h0002, 16'h0003, 1'b0);
    send_triangle(16'h0004, 16'h0005, 16'h0006, 1'b0);
    send_triangle(16'h0007, 16'h0008, 16'h0000, 1'b0);
    send_triangle(16'hAAAA, 16'h5555, 16'h0001, 1'b0);
    send_triangle(16'h0002, 16'h0003, 16'h0004, 1'b0);
    send_triangle(16'h0006, 16'h0006, 16'h0009, 1'b0);
    send_triangle(16'h0000, 16'hFFFF, 16'h0001, 1'b1);
    send_triangle(16'h0000, 16'hFFFF, 16'h0001, 1'b0);
    send_triangle(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_triangle(16'h1234, 16'h1234, 16'h1234, 1'b1);
    send_triangle(16'h8000, 16'h7FFF, 16'h0100, 1'b0);
    send_triangle(16'h7FFF, 16'h8000, 16'h0100, 1'b0);
    send_triangle(16'h0100, 16'h8000, 16'h7FFF, 1'b1);

    while (sent < ITEMS) begin
      mode     = $urandom_range(0, 9);
      len      = $urandom_range(1, 40);
      base     = VERTEX_W'($urandom);
      span     = $urandom_range(3, 24);
      gap_rate = $urandom_range(0, 3);
      for (int k = 0; k < len && sent < ITEMS; k++) begin
        calm = (sent >= ITEMS - CALM);
        if (sent == 700) long_hold_go = 1'b1;
        if (sent == 1300) begin
          triangle.valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end else if (!calm && $urandom_range(0, 15) < gap_rate) begin
          hold_source($urandom_range(1, 16));
        end
        if (mode == 0) begin
          t[0] = VERTEX_W'($urandom);
          t[1] = VERTEX_W'($urandom);
          t[2] = VERTEX_W'($urandom);
          last = ($urandom_range(0, 15) == 0);
        end else begin
          if (k == 0 || $urandom_range(0, 4) == 0) begin
            t[0] = base + VERTEX_W'($urandom_range(0, span - 1));
            t[1] = base + VERTEX_W'($urandom_range(0, span - 1));
          end else begin
            t[0] = p1;
            t[1] = p2;
          end
          t[2] = base + VERTEX_W'($urandom_range(0, span - 1));
          p1   = t[1];
          p2   = t[2];
          last = (k == len - 1);
        end
        r = $urandom_range(0, 2);
        send_triangle(t[r], t[(r + 1) % 3], t[(r + 2) % 3], last);
      end
    end

    triangle.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
